[hw/rtl/cloud_in_cell_deposit_unit_macros.svh]
// ----------------------------------------------------------------------------
// cloud_in_cell_deposit_unit_macros.svh
// Assertion macros shared by the cloud-in-cell deposit unit.
// ----------------------------------------------------------------------------
`ifndef CLOUD_IN_CELL_DEPOSIT_UNIT_MACROS_SVH
`define CLOUD_IN_CELL_DEPOSIT_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define CICD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define CICD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/cicd_pkg.sv]
// ----------------------------------------------------------------------------
// cicd_pkg
// Types, constants and codes of the cloud-in-cell deposit unit.
// ----------------------------------------------------------------------------
package cicd_pkg;

   // Grid geometry default
   localparam int GRID_SIZE_DEF = 32;

   // Field widths
   localparam int POS_W    = 32;
   localparam int CSR_W    = 32;
   localparam int VAL_W    = 48;
   localparam int IDX_W    = 15;
   localparam int FRAC_W   = 16;
   localparam int CSR_IDX_W = 2;

   // Fixed point constants
   localparam logic [FRAC_W:0]  ONE_Q16 = 17'h10000;
   localparam logic [VAL_W-1:0] VAL_MAX = 48'hFFFF_FFFF_FFFF;

   // Register reset values
   localparam logic [CSR_W-1:0] CELL_SCALE_RST    = 32'h0100_0000;
   localparam logic [CSR_W-1:0] DENSITY_SCALE_RST = 32'h0001_0000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SCALE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DENSITY_SCALE = 2'd1;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_DROP = 2'd1,
      STAT_SAT  = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SX,
      ST_SY,
      ST_SZ,
      ST_MS,
      ST_MC,
      ST_T1,
      ST_T2,
      ST_I1,
      ST_I2,
      ST_WR,
      ST_RD,
      ST_DONE
   } state_type;

   // Request payload
   typedef struct packed {
      logic             req_type;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
      logic [POS_W-1:0] mass_weight;
      logic [IDX_W-1:0] cell_index;
   } req_payload_type;

   // Response payload
   typedef struct packed {
      status_type       status;
      logic [VAL_W-1:0] cell_value;
   } rsp_payload_type;

endpackage

[hw/rtl/cicd_mul.sv]
// ----------------------------------------------------------------------------
// cicd_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module cicd_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] prod_ff
);

   // Register the product every cycle
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

endmodule

[hw/rtl/cicd_mem.sv]
// ----------------------------------------------------------------------------
// cicd_mem
// Single-port density grid memory with registered read data.
// ----------------------------------------------------------------------------
module cicd_mem #(
   parameter int DEPTH  = cicd_pkg::GRID_SIZE_DEF ** 3,
   parameter int ADDR_W = $clog2(cicd_pkg::GRID_SIZE_DEF ** 3)
) (
   input  logic                      clock,
   input  logic                      mem_we,
   input  logic                      mem_re,
   input  logic [ADDR_W-1:0]         mem_addr,
   input  logic [cicd_pkg::VAL_W-1:0] mem_wdata,
   output logic [cicd_pkg::VAL_W-1:0] rdata_ff
);

   logic [cicd_pkg::VAL_W-1:0] grid_ff [DEPTH];

   // Write or read one cell per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_ff[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= grid_ff[mem_addr];
      end
   end

endmodule

[hw/rtl/cicd_seq.sv]
// ----------------------------------------------------------------------------
// cicd_seq
// Sequencer and datapath: splits positions, forms the trilinear weights and
// increments on the shared multiplier, and updates eight grid cells.
// ----------------------------------------------------------------------------
module cicd_seq #(
   parameter int GRID_SIZE = cicd_pkg::GRID_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  cicd_pkg::req_payload_type         req_data,
   input  logic [cicd_pkg::CSR_W-1:0]        cell_scale,
   input  logic [cicd_pkg::CSR_W-1:0]        density_scale,
   output logic                              res_valid,
   input  logic                              res_ready,
   output cicd_pkg::rsp_payload_type         res_data,
   output logic [31:0]                       mul_a,
   output logic [31:0]                       mul_b,
   input  logic [63:0]                       mul_prod,
   output logic                              mem_we,
   output logic                              mem_re,
   output logic [$clog2(GRID_SIZE**3)-1:0]   mem_addr,
   output logic [cicd_pkg::VAL_W-1:0]        mem_wdata,
   input  logic [cicd_pkg::VAL_W-1:0]        mem_rdata
);

   localparam int CW         = $clog2(GRID_SIZE);
   localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE * GRID_SIZE;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam logic [AW-1:0] G_A     = AW'(GRID_SIZE);
   localparam logic [AW-1:0] LAST_A  = AW'(CELL_COUNT - 1);
   localparam logic [31:0]   COUNT_W = 32'(CELL_COUNT);
   localparam logic [23:0]   G_CELL  = 24'(GRID_SIZE);
   localparam logic [CW-1:0] G_LAST  = CW'(GRID_SIZE - 1);

   localparam int VW = cicd_pkg::VAL_W;
   localparam int FW = cicd_pkg::FRAC_W;

   cicd_pkg::state_type       state_ff, state_in;
   cicd_pkg::req_payload_type req_ff, req_in;
   cicd_pkg::status_type      status_ff, status_in;

   logic [CW-1:0] lo_ff [3];
   logic [CW-1:0] lo_in [3];
   logic [CW-1:0] hi_ff [3];
   logic [CW-1:0] hi_in [3];
   logic [FW-1:0] fr_ff [3];
   logic [FW-1:0] fr_in [3];

   logic          oob_ff, oob_in;
   logic          sat_ff, sat_in;
   logic [VW-1:0] m_ff, m_in;
   logic [2:0]    corner_ff, corner_in;
   logic [FW:0]   t_ff, t_in;
   logic [31:0]   plo_ff, plo_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] clr_ff, clr_in;

   // Position split from the product
   logic [23:0]   split_cell;
   logic [FW-1:0] split_frac;
   logic          split_oob;
   logic [CW-1:0] split_lo;
   logic [CW-1:0] split_hi;
   logic          cap_en;
   logic [1:0]    cap_axis;

   // Corner weights and coordinates
   logic [FW:0]   w_x, w_y, w_z;
   logic [CW-1:0] c_x, c_y, c_z;
   logic [AW-1:0] corner_addr;

   // Accumulate
   logic [VW:0]   inc_w;
   logic [VW:0]   sum_w;
   logic [VW-1:0] sum_sat;
   logic          idx_oob;

   // Split one axis: integer cell in bits 63..40, fraction in bits 39..24
   assign split_cell = mul_prod[63:40];
   assign split_frac = mul_prod[39:24];
   assign split_oob  = (split_cell >= G_CELL);
   assign split_lo   = split_cell[CW-1:0];
   assign split_hi   = (split_lo == G_LAST) ? '0 : split_lo + CW'(1);

   // Pick the weight and coordinate of each axis for the current corner
   assign w_x = corner_ff[2] ? {1'b0, fr_ff[0]} : cicd_pkg::ONE_Q16 - {1'b0, fr_ff[0]};
   assign w_y = corner_ff[1] ? {1'b0, fr_ff[1]} : cicd_pkg::ONE_Q16 - {1'b0, fr_ff[1]};
   assign w_z = corner_ff[0] ? {1'b0, fr_ff[2]} : cicd_pkg::ONE_Q16 - {1'b0, fr_ff[2]};
   assign c_x = corner_ff[2] ? hi_ff[0] : lo_ff[0];
   assign c_y = corner_ff[1] ? hi_ff[1] : lo_ff[1];
   assign c_z = corner_ff[0] ? hi_ff[2] : lo_ff[2];
   assign corner_addr = (AW'(c_x) * G_A + AW'(c_y)) * G_A + AW'(c_z);

   // Increment = (m_hi * t) << 16 + (m_lo * t) >> 16, then saturating add
   assign inc_w   = {1'b0, mul_prod[31:0], 16'b0} + (VW+1)'(plo_ff);
   assign sum_w   = {1'b0, mem_rdata} + {1'b0, inc_w[VW-1:0]};
   assign sum_sat = sum_w[VW] ? cicd_pkg::VAL_MAX : sum_w[VW-1:0];

   assign idx_oob = (32'(req_ff.cell_index) >= COUNT_W);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cicd_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_A) state_in = cicd_pkg::ST_IDLE;
         end
         cicd_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = req_data.req_type ? cicd_pkg::ST_RD : cicd_pkg::ST_SX;
            end
         end
         cicd_pkg::ST_SX: state_in = cicd_pkg::ST_SY;
         cicd_pkg::ST_SY: state_in = cicd_pkg::ST_SZ;
         cicd_pkg::ST_SZ: state_in = cicd_pkg::ST_MS;
         cicd_pkg::ST_MS: state_in = cicd_pkg::ST_MC;
         cicd_pkg::ST_MC: begin
            state_in = oob_ff ? cicd_pkg::ST_DONE : cicd_pkg::ST_T1;
         end
         cicd_pkg::ST_T1: state_in = cicd_pkg::ST_T2;
         cicd_pkg::ST_T2: state_in = cicd_pkg::ST_I1;
         cicd_pkg::ST_I1: state_in = cicd_pkg::ST_I2;
         cicd_pkg::ST_I2: state_in = cicd_pkg::ST_WR;
         cicd_pkg::ST_WR: begin
            state_in = (&corner_ff) ? cicd_pkg::ST_DONE : cicd_pkg::ST_T1;
         end
         cicd_pkg::ST_RD: state_in = cicd_pkg::ST_DONE;
         cicd_pkg::ST_DONE: begin
            if (res_ready) state_in = cicd_pkg::ST_IDLE;
         end
         default: state_in = cicd_pkg::ST_IDLE;
      endcase
   end

   // Handshakes, multiplier operands and memory port
   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = addr_ff;
      mem_wdata = sum_sat;
      unique case (state_ff)
         cicd_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
         end
         cicd_pkg::ST_IDLE: req_ready = 1'b1;
         cicd_pkg::ST_SX: begin
            mul_a = req_ff.pos_x;
            mul_b = cell_scale;
         end
         cicd_pkg::ST_SY: begin
            mul_a = req_ff.pos_y;
            mul_b = cell_scale;
         end
         cicd_pkg::ST_SZ: begin
            mul_a = req_ff.pos_z;
            mul_b = cell_scale;
         end
         cicd_pkg::ST_MS: begin
            mul_a = req_ff.mass_weight;
            mul_b = density_scale;
         end
         cicd_pkg::ST_T1: begin
            mul_a    = 32'(w_x);
            mul_b    = 32'(w_y);
            mem_re   = 1'b1;
            mem_addr = corner_addr;
         end
         cicd_pkg::ST_T2: begin
            mul_a = 32'(mul_prod[32:16]);
            mul_b = 32'(w_z);
         end
         cicd_pkg::ST_I1: begin
            mul_a = m_ff[31:0];
            mul_b = 32'(mul_prod[32:16]);
         end
         cicd_pkg::ST_I2: begin
            mul_a = 32'(m_ff[VW-1:32]);
            mul_b = 32'(t_ff);
         end
         cicd_pkg::ST_WR: mem_we = 1'b1;
         cicd_pkg::ST_RD: begin
            mem_re   = !idx_oob;
            mem_addr = AW'(req_ff.cell_index);
         end
         cicd_pkg::ST_DONE: res_valid = 1'b1;
         default: ;
      endcase
   end

   // Read results carry the cell; everything else carries zero
   assign res_data.status     = status_ff;
   assign res_data.cell_value = (req_ff.req_type && status_ff == cicd_pkg::STAT_OK) ?
                                mem_rdata : '0;

   // Capture axis x, y, z in the cycle after each split product is issued
   always_comb begin
      cap_en   = 1'b0;
      cap_axis = 2'd0;
      unique case (state_ff)
         cicd_pkg::ST_SY: begin
            cap_en   = 1'b1;
            cap_axis = 2'd0;
         end
         cicd_pkg::ST_SZ: begin
            cap_en   = 1'b1;
            cap_axis = 2'd1;
         end
         cicd_pkg::ST_MS: begin
            cap_en   = 1'b1;
            cap_axis = 2'd2;
         end
         default: ;
      endcase
   end

   // Datapath register updates
   always_comb begin
      req_in    = req_ff;
      status_in = status_ff;
      oob_in    = oob_ff;
      sat_in    = sat_ff;
      m_in      = m_ff;
      corner_in = corner_ff;
      t_in      = t_ff;
      plo_in    = plo_ff;
      addr_in   = addr_ff;
      clr_in    = clr_ff;
      for (int k = 0; k < 3; k++) begin
         lo_in[k] = lo_ff[k];
         hi_in[k] = hi_ff[k];
         fr_in[k] = fr_ff[k];
         if (cap_en && cap_axis == 2'(k)) begin
            lo_in[k] = split_lo;
            hi_in[k] = split_hi;
            fr_in[k] = split_frac;
         end
      end
      if (cap_en) oob_in = oob_ff | split_oob;

      unique case (state_ff)
         cicd_pkg::ST_CLEAR: clr_in = clr_ff + AW'(1);
         cicd_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               oob_in = 1'b0;
               sat_in = 1'b0;
            end
         end
         cicd_pkg::ST_MC: begin
            m_in      = mul_prod[63:16];
            corner_in = '0;
            if (oob_ff) status_in = cicd_pkg::STAT_DROP;
         end
         cicd_pkg::ST_T1: addr_in = corner_addr;
         cicd_pkg::ST_I1: t_in = mul_prod[32:16];
         cicd_pkg::ST_I2: plo_in = mul_prod[47:16];
         cicd_pkg::ST_WR: begin
            sat_in    = sat_ff | sum_w[VW];
            corner_in = corner_ff + 3'd1;
            if (&corner_ff) begin
               status_in = (sat_ff | sum_w[VW]) ? cicd_pkg::STAT_SAT : cicd_pkg::STAT_OK;
            end
         end
         cicd_pkg::ST_RD: begin
            status_in = idx_oob ? cicd_pkg::STAT_DROP : cicd_pkg::STAT_OK;
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cicd_pkg::ST_CLEAR;
         clr_ff    <= '0;
         corner_ff <= '0;
         oob_ff    <= 1'b0;
         sat_ff    <= 1'b0;
         status_ff <= cicd_pkg::STAT_OK;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         corner_ff <= corner_in;
         oob_ff    <= oob_in;
         sat_ff    <= sat_in;
         status_ff <= status_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      m_ff    <= m_in;
      t_ff    <= t_in;
      plo_ff  <= plo_in;
      addr_ff <= addr_in;
      for (int k = 0; k < 3; k++) begin
         lo_ff[k] <= lo_in[k];
         hi_ff[k] <= hi_in[k];
         fr_ff[k] <= fr_in[k];
      end
   end

endmodule

[hw/rtl/cloud_in_cell_deposit_unit.sv]
// ----------------------------------------------------------------------------
// cloud_in_cell_deposit_unit
// Cloud-in-cell mass assignment onto a periodic cubic Q32.16 density grid.
//
// Channel   Dir   Handshake                Payload
// req_      in    req_valid / req_ready    deposit (x, y, z, weight) or read
// rsp_      out   rsp_valid / rsp_ready    status, cell value
// csr_      in    csr_valid / csr_ready    register index, 32-bit data
//
// A deposit steps through states SX, SY, SZ, MS and MC to split the three
// positions and scale the weight, then T1, T2, I1, I2 and WR per corner for
// eight corners, paced by the single shared 32x32 multiplier (four products
// per corner) and the one port of the grid memory. A read uses state RD.
// After reset a clearing pass writes zero to all GRID_SIZE^3 cells, one per
// cycle, with req_ready low. The result register lets the next item be
// accepted while a result waits; the sequencer holds a finished result while
// that register stays full.
// ----------------------------------------------------------------------------
`include "cloud_in_cell_deposit_unit_macros.svh"

module cloud_in_cell_deposit_unit #(
   parameter int GRID_SIZE = cicd_pkg::GRID_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  cicd_pkg::req_payload_type       req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cicd_pkg::rsp_payload_type       rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cicd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cicd_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE * GRID_SIZE;
   localparam int AW         = $clog2(CELL_COUNT);

   logic [cicd_pkg::CSR_W-1:0] cell_scale_ff, cell_scale_in;
   logic [cicd_pkg::CSR_W-1:0] density_scale_ff, density_scale_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   cicd_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic                      res_valid;
   logic                      res_ready;
   cicd_pkg::rsp_payload_type res_data;

   logic [31:0]               mul_a, mul_b;
   logic [63:0]               mul_prod;
   logic                      mem_we, mem_re;
   logic [AW-1:0]             mem_addr;
   logic [cicd_pkg::VAL_W-1:0] mem_wdata, mem_rdata;

   // Register writes; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cell_scale_in    = cell_scale_ff;
      density_scale_in = density_scale_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cicd_pkg::CSR_CELL_SCALE:    cell_scale_in    = csr_wdata;
            cicd_pkg::CSR_DENSITY_SCALE: density_scale_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_scale_ff    <= cicd_pkg::CELL_SCALE_RST;
         density_scale_ff <= cicd_pkg::DENSITY_SCALE_RST;
      end else begin
         cell_scale_ff    <= cell_scale_in;
         density_scale_ff <= density_scale_in;
      end
   end

   // Result register: load a finished transaction when the slot frees up
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer and datapath
   cicd_seq #(
      .GRID_SIZE(GRID_SIZE)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .cell_scale    (cell_scale_ff),
      .density_scale (density_scale_ff),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res_data      (res_data),
      .mul_a         (mul_a),
      .mul_b         (mul_b),
      .mul_prod      (mul_prod),
      .mem_we        (mem_we),
      .mem_re        (mem_re),
      .mem_addr      (mem_addr),
      .mem_wdata     (mem_wdata),
      .mem_rdata     (mem_rdata)
   );

   // Shared multiplier
   cicd_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (mul_prod)
   );

   // Density grid
   cicd_mem #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (AW)
   ) u_mem (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .rdata_ff  (mem_rdata)
   );

   // One transaction at a time: accepting one drops ready for the next cycle
   `CICD_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "second transaction accepted while busy")

   // Dropped or saturated results never carry a cell value
   `CICD_ASSERT_SAME(a_value_only_ok, clock, reset, rsp_valid && (rsp_data.status != cicd_pkg::STAT_OK), rsp_data.cell_value == '0, "nonzero value on a failed transaction")

   // A result handed over by the sequencer shows up on the port
   `CICD_ASSERT_NEXT(a_result_loaded, clock, reset, res_valid && res_ready, rsp_valid, "finished transaction not presented")

endmodule

[tb/cloud_in_cell_deposit_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cloud_in_cell_deposit_unit_tb
// Self-checking bench for the cloud-in-cell deposit unit. A clocked driver
// offers deposit and read transactions from a queue that the stimulus process
// keeps topped up. A clocked monitor mirrors every accepted transaction on a
// local copy of the density grid and scores each returned result, field by
// field, in order. Directed corners come first, then random phases that
// sweep both scale registers across their extremes, with varying back
// pressure on both channels.
// ----------------------------------------------------------------------------
module cloud_in_cell_deposit_unit_tb;

   localparam int GRID            = cicd_pkg::GRID_SIZE_DEF;
   localparam int CELL_COUNT      = GRID * GRID * GRID;
   localparam logic REQ_DEPOSIT   = 1'b0;
   localparam logic REQ_READ      = 1'b1;
   localparam logic [cicd_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [cicd_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 2'd3;
   localparam int DRAIN_CYCLES    = 64;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int LIMIT_CYCLES    = 400000;
   localparam int HOT_CELL_DEPTH  = 64;
   localparam int QUEUE_AHEAD     = 4;
   localparam int PHASE_ITEMS     = 75;

   logic                              clock     = 1'b0;
   logic                              reset     = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   cicd_pkg::req_payload_type         req_data  = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   cicd_pkg::rsp_payload_type         rsp_data;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [cicd_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [cicd_pkg::CSR_W-1:0]        csr_wdata = '0;

   // Mirror of the grid and the live register values
   logic [cicd_pkg::VAL_W-1:0]        density_mirror [CELL_COUNT];
   logic [cicd_pkg::CSR_W-1:0]        cell_scale_cfg    = cicd_pkg::CELL_SCALE_RST;
   logic [cicd_pkg::CSR_W-1:0]        density_scale_cfg = cicd_pkg::DENSITY_SCALE_RST;

   cicd_pkg::req_payload_type         particle_queue [$];
   cicd_pkg::rsp_payload_type         due_results [$];
   int unsigned                       hot_cells [$];

   logic                   req_fire = 1'b0;
   int                     sender_idle_pct   = 0;
   int                     receiver_idle_pct = 0;
   int                     holds_asked  = 0;
   int                     holds_served = 0;
   int                     hold_left    = 0;
   int                     cycle_count  = 0;
   int                     fail_count   = 0;

   cloud_in_cell_deposit_unit #(
      .GRID_SIZE (GRID)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one transaction to the grid mirror and return its result
   function automatic cicd_pkg::rsp_payload_type cic_apply(
      input cicd_pkg::req_payload_type item);
      cicd_pkg::rsp_payload_type  res;
      logic [cicd_pkg::POS_W-1:0] pos [3];
      logic [63:0]                prod;
      int unsigned                lo [3];
      int unsigned                hi [3];
      logic [16:0]                wt [3][2];
      logic [63:0]                mass_q;
      logic [63:0]                trilin;
      logic [63:0]                incr;
      logic [cicd_pkg::VAL_W:0]   sum;
      int unsigned                idx;
      int unsigned                cx;
      int unsigned                cy;
      int unsigned                cz;
      bit                         saturated;
      res.status     = cicd_pkg::STAT_OK;
      res.cell_value = '0;
      saturated      = 1'b0;
      if (item.req_type == REQ_READ) begin
         if (int'(item.cell_index) >= CELL_COUNT)
            res.status = cicd_pkg::STAT_DROP;
         else
            res.cell_value = density_mirror[item.cell_index];
         return res;
      end
      pos[0] = item.pos_x;
      pos[1] = item.pos_y;
      pos[2] = item.pos_z;
      // Split each axis into a lower cell and a Q0.16 fraction
      for (int a = 0; a < 3; a++) begin
         prod = 64'(pos[a]) * 64'(cell_scale_cfg);
         if (prod[63:40] >= GRID) begin
            res.status = cicd_pkg::STAT_DROP;
            return res;
         end
         lo[a]    = 32'(prod[63:40]);
         hi[a]    = (lo[a] + 1 == GRID) ? 0 : lo[a] + 1;
         wt[a][0] = cicd_pkg::ONE_Q16 - 17'(prod[39:24]);
         wt[a][1] = 17'(prod[39:24]);
      end
      mass_q = (64'(item.mass_weight) * 64'(density_scale_cfg)) >> 16;
      // Spread the scaled mass over the eight corners with saturation
      for (int bx = 0; bx < 2; bx++) begin
         for (int by = 0; by < 2; by++) begin
            for (int bz = 0; bz < 2; bz++) begin
               trilin = (64'(wt[0][bx]) * 64'(wt[1][by])) >> 16;
               trilin = (trilin * 64'(wt[2][bz])) >> 16;
               incr   = (mass_q * trilin) >> 16;
               cx     = bx ? hi[0] : lo[0];
               cy     = by ? hi[1] : lo[1];
               cz     = bz ? hi[2] : lo[2];
               idx    = (cx * GRID + cy) * GRID + cz;
               sum    = {1'b0, density_mirror[idx]} + incr[cicd_pkg::VAL_W:0];
               if (sum > {1'b0, cicd_pkg::VAL_MAX}) begin
                  density_mirror[idx] = cicd_pkg::VAL_MAX;
                  saturated = 1'b1;
               end else begin
                  density_mirror[idx] = sum[cicd_pkg::VAL_W-1:0];
               end
               hot_cells.push_back(idx);
               if (hot_cells.size() > HOT_CELL_DEPTH)
                  void'(hot_cells.pop_front());
            end
         end
      end
      if (saturated)
         res.status = cicd_pkg::STAT_SAT;
      return res;
   endfunction

   // Score returned transactions, then mirror the accepted one
   always @(posedge clock) begin
      cicd_pkg::rsp_payload_type want;
      req_fire <= req_valid && req_ready;
      if (!reset) begin
         cycle_count++;
         if (cycle_count > LIMIT_CYCLES) begin
            $display("cloud_in_cell_deposit_unit_tb: FAIL");
            $finish;
         end else begin
            if (rsp_valid && rsp_ready) begin
               if (due_results.size() == 0) begin
                  $error("result with no transaction outstanding: status %0d value %0h",
                         rsp_data.status, rsp_data.cell_value);
                  fail_count++;
               end else begin
                  want = due_results.pop_front();
                  if (rsp_data.status !== want.status) begin
                     $error("status mismatch: expected %0d, actual %0d",
                            want.status, rsp_data.status);
                     fail_count++;
                  end
                  if (rsp_data.cell_value !== want.cell_value) begin
                     $error("cell_value mismatch: expected %0h, actual %0h",
                            want.cell_value, rsp_data.cell_value);
                     fail_count++;
                  end
               end
            end
            if (req_valid && req_ready) begin
               due_results.push_back(cic_apply(req_data));
               void'(particle_queue.pop_front());
            end
         end
      end
   end

   // Offer the head of the queue; hold it until the handshake completes
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_fire)) begin
         if (particle_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= particle_queue[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Drive result back pressure, with an occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_served < holds_asked) begin
         holds_served++;
         hold_left = HOLD_OFF_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic write_csr(input logic [cicd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [cicd_pkg::CSR_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         cicd_pkg::CSR_CELL_SCALE:    cell_scale_cfg    = val;
         cicd_pkg::CSR_DENSITY_SCALE: density_scale_cfg = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idle(input int sender_pct, input int receiver_pct);
      @(posedge clock);
      sender_idle_pct   = sender_pct;
      receiver_idle_pct = receiver_pct;
   endtask

   // Hold the stimulus until the queue is empty and every outstanding result has returned
   task automatic wait_drained();
      while (particle_queue.size() != 0 || due_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic push_item(input cicd_pkg::req_payload_type item);
      do @(posedge clock); while (particle_queue.size() >= QUEUE_AHEAD);
      particle_queue.push_back(item);
   endtask

   task automatic queue_deposit(input logic [cicd_pkg::POS_W-1:0] x, y, z,
                                input logic [cicd_pkg::POS_W-1:0] m);
      cicd_pkg::req_payload_type item;
      item             = '0;
      item.req_type    = REQ_DEPOSIT;
      item.pos_x       = x;
      item.pos_y       = y;
      item.pos_z       = z;
      item.mass_weight = m;
      push_item(item);
   endtask

   task automatic queue_read(input logic [cicd_pkg::IDX_W-1:0] idx);
      cicd_pkg::req_payload_type item;
      item            = '0;
      item.req_type   = REQ_READ;
      item.cell_index = idx;
      push_item(item);
   endtask

   // Pick a position mostly inside the grid at the current cell scale
   function automatic logic [cicd_pkg::POS_W-1:0] pick_pos();
      logic [63:0]                span;
      logic [cicd_pkg::POS_W-1:0] top;
      int unsigned                roll;
      if (cell_scale_cfg == '0)
         span = 64'hFFFF_FFFF;
      else
         span = ((64'(GRID) << 40) - 1) / 64'(cell_scale_cfg);
      top  = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
      roll = $urandom_range(99);
      if (roll < 70)
         return $urandom_range(top, 0);
      if (roll < 85)
         return top - $urandom_range((top < 32'h3FFFF) ? top : 32'h3FFFF, 0);
      return $urandom;
   endfunction

   task automatic queue_random_item();
      cicd_pkg::req_payload_type item;
      int unsigned               roll;
      int unsigned               mroll;
      item.req_type    = REQ_DEPOSIT;
      item.pos_x       = $urandom;
      item.pos_y       = $urandom;
      item.pos_z       = $urandom;
      item.mass_weight = $urandom;
      item.cell_index  = cicd_pkg::IDX_W'($urandom);
      roll  = $urandom_range(99);
      mroll = $urandom_range(99);
      if (roll < 30) begin
         // Read back, mostly from recently touched cells
         item.req_type = REQ_READ;
         if (hot_cells.size() != 0 && $urandom_range(99) < 70)
            item.cell_index =
               cicd_pkg::IDX_W'(hot_cells[$urandom_range(hot_cells.size() - 1)]);
      end else if (roll < 90) begin
         item.pos_x = pick_pos();
         item.pos_y = pick_pos();
         item.pos_z = pick_pos();
         if (mroll < 10)
            item.mass_weight = 32'hFFFF_FFFF;
         else if (mroll < 15)
            item.mass_weight = '0;
         else if (mroll < 30)
            item.mass_weight = $urandom_range(32'h0001_FFFF, 0);
      end
      push_item(item);
   endtask

   task automatic run_phase(input logic [cicd_pkg::CSR_W-1:0] cs, ds,
                            input int sender_pct, input int receiver_pct,
                            input bit long_hold);
      wait_drained();
      write_csr(cicd_pkg::CSR_CELL_SCALE, cs);
      write_csr(cicd_pkg::CSR_DENSITY_SCALE, ds);
      set_idle(sender_pct, receiver_pct);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (long_hold && n == 10) begin
            @(posedge clock);
            holds_asked++;
         end
         queue_random_item();
      end
   endtask

   initial begin
      foreach (density_mirror[i])
         density_mirror[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Unit scales: corners, wrap at the top edge, drops on each axis
      set_idle(14, 67);
      write_csr(cicd_pkg::CSR_CELL_SCALE, cicd_pkg::CELL_SCALE_RST);
      write_csr(cicd_pkg::CSR_DENSITY_SCALE, cicd_pkg::DENSITY_SCALE_RST);
      queue_deposit(32'h0, 32'h0, 32'h0, 32'h0001_0000);
      queue_read(cicd_pkg::IDX_W'(0));
      queue_deposit(32'h001F_8000, 32'h001F_8000, 32'h001F_8000, 32'h0002_0000);
      queue_read(cicd_pkg::IDX_W'(CELL_COUNT - 1));
      queue_read(cicd_pkg::IDX_W'(0));
      queue_read(cicd_pkg::IDX_W'((31 * GRID) * GRID + 31));
      queue_deposit(32'h0020_0000, 32'h0, 32'h0, 32'h0001_0000);
      queue_deposit(32'h0, 32'h0020_0000, 32'h0, 32'h0001_0000);
      queue_deposit(32'h0, 32'h0, 32'h0020_0000, 32'h0001_0000);
      queue_deposit(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_deposit(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF);
      queue_deposit(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h0);
      queue_read(cicd_pkg::IDX_W'((5 * GRID + 5) * GRID + 5));
      queue_deposit(32'h001F_FFFF, 32'h001F_FFFF, 32'h001F_FFFF, 32'h0001_0000);
      queue_read(cicd_pkg::IDX_W'(1));

      // Writes to unmapped indexes must leave both scales alone
      wait_drained();
      write_csr(CSR_UNMAPPED_LO, 32'hFFFF_FFFF);
      write_csr(CSR_UNMAPPED_HI, 32'hFFFF_FFFF);
      queue_deposit(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      queue_read(cicd_pkg::IDX_W'((1 * GRID + 1) * GRID + 1));

      // Full density scale: two whole-cell hits saturate the sum
      wait_drained();
      write_csr(cicd_pkg::CSR_DENSITY_SCALE, 32'hFFFF_FFFF);
      queue_deposit(32'h000A_0000, 32'h000A_0000, 32'h000A_0000, 32'hFFFF_FFFF);
      queue_deposit(32'h000A_0000, 32'h000A_0000, 32'h000A_0000, 32'hFFFF_FFFF);
      queue_read(cicd_pkg::IDX_W'((10 * GRID + 10) * GRID + 10));

      // Random phases across register extremes and idle patterns
      run_phase(32'h0100_0000, 32'h0001_0000, 14, 67, 1'b0);
      run_phase(32'hFFFF_FFFF, 32'h0000_0000, 14, 67, 1'b0);
      run_phase(32'h0800_0000, $urandom, 67, 14, 1'b0);
      run_phase(32'h0000_0000, 32'hFFFF_FFFF, 67, 14, 1'b0);
      run_phase($urandom_range(32'h0400_0000, 32'h0040_0000), 32'h0010_0000, 0, 0, 1'b1);
      run_phase(32'h0100_0000, 32'hFFFF_FFFF, 0, 0, 1'b0);

      // Let any stray result surface before the verdict
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0)
         $display("cloud_in_cell_deposit_unit_tb: PASS");
      else
         $display("cloud_in_cell_deposit_unit_tb: FAIL");
      $finish;
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/cicd_pkg.sv
hw/rtl/cicd_mul.sv
hw/rtl/cicd_mem.sv
hw/rtl/cicd_seq.sv
hw/rtl/cloud_in_cell_deposit_unit.sv
tb/cloud_in_cell_deposit_unit_tb.sv
